// File: hw/rtl/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types, constants and the arctangent table of the point rotator.
// ----------------------------------------------------------------------------
package apr_pkg;

	localparam int COORD_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int ANGLE_WIDTH = 16;
	// residual angle is angle * 2^ANGLE_SHIFT, two extra bits of headroom
	localparam int ANGLE_SHIFT = 16;
	localparam int Z_WIDTH     = ANGLE_WIDTH + ANGLE_SHIFT + 2;
	localparam int GUARD_BITS  = 14;
	localparam int GAIN_SHIFT  = 16;
	localparam int KGAIN_WIDTH = 32;
	localparam int ATAN_COUNT  = 24;

	// 0.6072529350 in Q1.30
	localparam logic signed [KGAIN_WIDTH-1:0] KGAIN = 32'sd652032874;

	localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN =
		ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2));

	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_X = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Y = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Z = 2'd2;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef struct packed {
		logic  valid;
		axis_t axis;
	} apr_ctrl_t;

	// atan(2^-i) with 2^32 as a full turn
	function automatic logic signed [Z_WIDTH-1:0] atan_lut(input int unsigned idx);
		unique case (idx)
			0:  atan_lut = Z_WIDTH'(536870912);
			1:  atan_lut = Z_WIDTH'(316933406);
			2:  atan_lut = Z_WIDTH'(167458907);
			3:  atan_lut = Z_WIDTH'(85004756);
			4:  atan_lut = Z_WIDTH'(42667331);
			5:  atan_lut = Z_WIDTH'(21354465);
			6:  atan_lut = Z_WIDTH'(10679838);
			7:  atan_lut = Z_WIDTH'(5340245);
			8:  atan_lut = Z_WIDTH'(2670163);
			9:  atan_lut = Z_WIDTH'(1335087);
			10: atan_lut = Z_WIDTH'(667544);
			11: atan_lut = Z_WIDTH'(333772);
			12: atan_lut = Z_WIDTH'(166886);
			13: atan_lut = Z_WIDTH'(83443);
			14: atan_lut = Z_WIDTH'(41722);
			15: atan_lut = Z_WIDTH'(20861);
			16: atan_lut = Z_WIDTH'(10430);
			17: atan_lut = Z_WIDTH'(5215);
			18: atan_lut = Z_WIDTH'(2608);
			19: atan_lut = Z_WIDTH'(1304);
			20: atan_lut = Z_WIDTH'(652);
			21: atan_lut = Z_WIDTH'(326);
			22: atan_lut = Z_WIDTH'(163);
			23: atan_lut = Z_WIDTH'(81);
			default: atan_lut = '0;
		endcase
	endfunction

endpackage

// File: hw/rtl/axis_point_rotator.sv
// ----------------------------------------------------------------------------
// axis_point_rotator
// Rotates a 3D point about the X, Y or Z axis through a programmable pivot.
// ----------------------------------------------------------------------------
// Usage
//   cfg channel: cfg_index 0..2 selects pivot_x, pivot_y or pivot_z, cfg_data
//   is the signed value; cfg_ready is always high, index 3 is dropped.
//   in channel: command selects the axis (3 passes the point through),
//   turn_angle is a binary angle, coord_x/y/z the point.
//   out channel: rotated_x/y/z, plane coordinates rounded and saturated.
// The pipeline has two prep stages (offset and gain multiply), one CORDIC
// cell per stage, then the rounding/output register. Throughput is one
// transaction per cycle while out_ready is high; every stage has its own
// valid and accepts a new transaction whenever it is empty or its successor
// moves on. When the receiver stalls, the stages behind the output fill up
// one by one and in_ready falls once all CORDIC_STAGES + 3 are full.
// Reset empties the pipeline and clears the pivot to the origin.
// Pivots are read live, so they should only change with nothing in flight.
// ----------------------------------------------------------------------------
module axis_point_rotator import apr_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic signed [COORD_WIDTH-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic signed [ANGLE_WIDTH-1:0]  turn_angle,
	input  logic signed [COORD_WIDTH-1:0]  coord_x,
	input  logic signed [COORD_WIDTH-1:0]  coord_y,
	input  logic signed [COORD_WIDTH-1:0]  coord_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [COORD_WIDTH-1:0]  rotated_x,
	output logic signed [COORD_WIDTH-1:0]  rotated_y,
	output logic signed [COORD_WIDTH-1:0]  rotated_z
);

	localparam int WW = COORD_WIDTH + 17;

	logic signed [COORD_WIDTH-1:0] pivot_x_q, pivot_y_q, pivot_z_q;

	apr_ctrl_t                     ctrl_c  [CORDIC_STAGES+1];
	logic                          ready_c [CORDIC_STAGES+1];
	logic signed [WW-1:0]          wa_c    [CORDIC_STAGES+1];
	logic signed [WW-1:0]          wb_c    [CORDIC_STAGES+1];
	logic signed [Z_WIDTH-1:0]     z_c     [CORDIC_STAGES+1];
	logic signed [COORD_WIDTH-1:0] cx_c    [CORDIC_STAGES+1];
	logic signed [COORD_WIDTH-1:0] cy_c    [CORDIC_STAGES+1];
	logic signed [COORD_WIDTH-1:0] cz_c    [CORDIC_STAGES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_x_q <= '0;
			pivot_y_q <= '0;
			pivot_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PIVOT_X: pivot_x_q <= cfg_data;
				REG_PIVOT_Y: pivot_y_q <= cfg_data;
				REG_PIVOT_Z: pivot_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	apr_prep #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.turn_angle (turn_angle),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.pivot_x    (pivot_x_q),
		.pivot_y    (pivot_y_q),
		.pivot_z    (pivot_z_q),
		.ctrl_o     (ctrl_c[0]),
		.ready_i    (ready_c[0]),
		.wa_o       (wa_c[0]),
		.wb_o       (wb_c[0]),
		.z_o        (z_c[0]),
		.cx_o       (cx_c[0]),
		.cy_o       (cy_c[0]),
		.cz_o       (cz_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		apr_cordic_cell #(
			.COORD_WIDTH (COORD_WIDTH),
			.STAGE       (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl_i  (ctrl_c[i]),
			.ready_o (ready_c[i]),
			.wa_i    (wa_c[i]),
			.wb_i    (wb_c[i]),
			.z_i     (z_c[i]),
			.cx_i    (cx_c[i]),
			.cy_i    (cy_c[i]),
			.cz_i    (cz_c[i]),
			.ctrl_o  (ctrl_c[i+1]),
			.ready_i (ready_c[i+1]),
			.wa_o    (wa_c[i+1]),
			.wb_o    (wb_c[i+1]),
			.z_o     (z_c[i+1]),
			.cx_o    (cx_c[i+1]),
			.cy_o    (cy_c[i+1]),
			.cz_o    (cz_c[i+1])
		);
	end

	apr_post #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_i    (ctrl_c[CORDIC_STAGES]),
		.ready_o   (ready_c[CORDIC_STAGES]),
		.wa_i      (wa_c[CORDIC_STAGES]),
		.wb_i      (wb_c[CORDIC_STAGES]),
		.cx_i      (cx_c[CORDIC_STAGES]),
		.cy_i      (cy_c[CORDIC_STAGES]),
		.cz_i      (cz_c[CORDIC_STAGES]),
		.pivot_x   (pivot_x_q),
		.pivot_y   (pivot_y_q),
		.pivot_z   (pivot_z_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y),
		.rotated_z (rotated_z)
	);

endmodule

// File: hw/rtl/apr_prep.sv
// ----------------------------------------------------------------------------
// apr_prep
// Plane select, pivot offset, angle fold and gain compensation (two stages).
// ----------------------------------------------------------------------------
module apr_prep import apr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic signed [ANGLE_WIDTH-1:0] turn_angle,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	input  logic signed [COORD_WIDTH-1:0] pivot_x,
	input  logic signed [COORD_WIDTH-1:0] pivot_y,
	input  logic signed [COORD_WIDTH-1:0] pivot_z,
	output apr_ctrl_t                     ctrl_o,
	input  logic                          ready_i,
	output logic signed [COORD_WIDTH+16:0] wa_o,
	output logic signed [COORD_WIDTH+16:0] wb_o,
	output logic signed [Z_WIDTH-1:0]     z_o,
	output logic signed [COORD_WIDTH-1:0] cx_o,
	output logic signed [COORD_WIDTH-1:0] cy_o,
	output logic signed [COORD_WIDTH-1:0] cz_o
);

	localparam int WW = COORD_WIDTH + 17;
	localparam int PW = COORD_WIDTH + 1 + KGAIN_WIDTH;

	axis_t                          axis_in;
	logic signed [COORD_WIDTH-1:0]  a, b, pa, pb;
	logic signed [COORD_WIDTH:0]    da_n, db_n;
	logic signed [ANGLE_WIDTH-1:0]  ang_n;
	logic                           neg_n;

	apr_ctrl_t                      ctrl_s1;
	logic signed [COORD_WIDTH:0]    da_s1, db_s1;
	logic signed [ANGLE_WIDTH-1:0]  ang_s1;
	logic                           neg_s1;
	logic signed [COORD_WIDTH-1:0]  cx_s1, cy_s1, cz_s1;
	logic                           ready_s1;

	logic signed [PW-1:0]           prod_a, prod_b;
	logic signed [WW-1:0]           wa_n, wb_n;
	logic signed [Z_WIDTH-1:0]      z_n;

	apr_ctrl_t                      ctrl_s2;
	logic signed [WW-1:0]           wa_s2, wb_s2;
	logic signed [Z_WIDTH-1:0]      z_s2;
	logic signed [COORD_WIDTH-1:0]  cx_s2, cy_s2, cz_s2;
	logic                           ready_s2;

	assign axis_in  = axis_t'(command);
	assign ready_s2 = !ctrl_s2.valid || ready_i;
	assign ready_s1 = !ctrl_s1.valid || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		unique case (axis_in)
			AXIS_X: begin
				a = coord_y; b = coord_z; pa = pivot_y; pb = pivot_z;
			end
			AXIS_Y: begin
				a = coord_x; b = coord_z; pa = pivot_x; pb = pivot_z;
			end
			AXIS_Z: begin
				a = coord_x; b = coord_y; pa = pivot_x; pb = pivot_y;
			end
			AXIS_NONE: begin
				a = '0; b = '0; pa = '0; pb = '0;
			end
		endcase
		da_n = $signed({a[COORD_WIDTH-1], a}) - $signed({pa[COORD_WIDTH-1], pa});
		db_n = $signed({b[COORD_WIDTH-1], b}) - $signed({pb[COORD_WIDTH-1], pb});
		// fold into the right half plane, adding or subtracting a half turn is
		// the same msb flip at this width
		neg_n = (turn_angle > QUARTER_TURN) || (turn_angle < -QUARTER_TURN);
		ang_n = neg_n ? {~turn_angle[ANGLE_WIDTH-1], turn_angle[ANGLE_WIDTH-2:0]}
		              : turn_angle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (ready_s1) begin
			ctrl_s1.valid <= in_valid;
			ctrl_s1.axis  <= axis_in;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			da_s1  <= da_n;
			db_s1  <= db_n;
			ang_s1 <= ang_n;
			neg_s1 <= neg_n;
			cx_s1  <= coord_x;
			cy_s1  <= coord_y;
			cz_s1  <= coord_z;
		end
	end

	always_comb begin
		prod_a = da_s1 * KGAIN;
		prod_b = db_s1 * KGAIN;
		// floor division by 2^16 leaves 14 guard fraction bits
		wa_n = prod_a[GAIN_SHIFT +: WW];
		wb_n = prod_b[GAIN_SHIFT +: WW];
		if (neg_s1) begin
			wa_n = -wa_n;
			wb_n = -wb_n;
		end
		z_n = {{(Z_WIDTH-ANGLE_WIDTH-ANGLE_SHIFT){ang_s1[ANGLE_WIDTH-1]}}, ang_s1,
		       {ANGLE_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (ready_s2) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid && ready_s2) begin
			wa_s2 <= wa_n;
			wb_s2 <= wb_n;
			z_s2  <= z_n;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			cz_s2 <= cz_s1;
		end
	end

	assign ctrl_o = ctrl_s2;
	assign wa_o   = wa_s2;
	assign wb_o   = wb_s2;
	assign z_o    = z_s2;
	assign cx_o   = cx_s2;
	assign cy_o   = cy_s2;
	assign cz_o   = cz_s2;

endmodule

// File: hw/rtl/apr_cordic_cell.sv
// ----------------------------------------------------------------------------
// apr_cordic_cell
// One CORDIC rotation step with its own register and handshake.
// ----------------------------------------------------------------------------
module apr_cordic_cell import apr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int STAGE       = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  apr_ctrl_t                      ctrl_i,
	output logic                           ready_o,
	input  logic signed [COORD_WIDTH+16:0] wa_i,
	input  logic signed [COORD_WIDTH+16:0] wb_i,
	input  logic signed [Z_WIDTH-1:0]      z_i,
	input  logic signed [COORD_WIDTH-1:0]  cx_i,
	input  logic signed [COORD_WIDTH-1:0]  cy_i,
	input  logic signed [COORD_WIDTH-1:0]  cz_i,
	output apr_ctrl_t                      ctrl_o,
	input  logic                           ready_i,
	output logic signed [COORD_WIDTH+16:0] wa_o,
	output logic signed [COORD_WIDTH+16:0] wb_o,
	output logic signed [Z_WIDTH-1:0]      z_o,
	output logic signed [COORD_WIDTH-1:0]  cx_o,
	output logic signed [COORD_WIDTH-1:0]  cy_o,
	output logic signed [COORD_WIDTH-1:0]  cz_o
);

	localparam int WW = COORD_WIDTH + 17;
	localparam logic signed [Z_WIDTH-1:0] ATAN = atan_lut(STAGE);

	logic signed [WW-1:0]          sa, sb, wa_n, wb_n;
	logic signed [Z_WIDTH-1:0]     z_n;

	apr_ctrl_t                     ctrl_q;
	logic signed [WW-1:0]          wa_q, wb_q;
	logic signed [Z_WIDTH-1:0]     z_q;
	logic signed [COORD_WIDTH-1:0] cx_q, cy_q, cz_q;

	assign ready_o = !ctrl_q.valid || ready_i;

	always_comb begin
		sa = wa_i >>> STAGE;
		sb = wb_i >>> STAGE;
		if (!z_i[Z_WIDTH-1]) begin
			wa_n = wa_i - sb;
			wb_n = wb_i + sa;
			z_n  = z_i - ATAN;
		end else begin
			wa_n = wa_i + sb;
			wb_n = wb_i - sa;
			z_n  = z_i + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (ready_o) begin
			ctrl_q <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_i.valid && ready_o) begin
			wa_q <= wa_n;
			wb_q <= wb_n;
			z_q  <= z_n;
			cx_q <= cx_i;
			cy_q <= cy_i;
			cz_q <= cz_i;
		end
	end

	assign ctrl_o = ctrl_q;
	assign wa_o   = wa_q;
	assign wb_o   = wb_q;
	assign z_o    = z_q;
	assign cx_o   = cx_q;
	assign cy_o   = cy_q;
	assign cz_o   = cz_q;

endmodule

// File: hw/rtl/apr_post.sv
// ----------------------------------------------------------------------------
// apr_post
// Rounding, pivot restore, saturation and the output register.
// ----------------------------------------------------------------------------
module apr_post import apr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  apr_ctrl_t                      ctrl_i,
	output logic                           ready_o,
	input  logic signed [COORD_WIDTH+16:0] wa_i,
	input  logic signed [COORD_WIDTH+16:0] wb_i,
	input  logic signed [COORD_WIDTH-1:0]  cx_i,
	input  logic signed [COORD_WIDTH-1:0]  cy_i,
	input  logic signed [COORD_WIDTH-1:0]  cz_i,
	input  logic signed [COORD_WIDTH-1:0]  pivot_x,
	input  logic signed [COORD_WIDTH-1:0]  pivot_y,
	input  logic signed [COORD_WIDTH-1:0]  pivot_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [COORD_WIDTH-1:0]  rotated_x,
	output logic signed [COORD_WIDTH-1:0]  rotated_y,
	output logic signed [COORD_WIDTH-1:0]  rotated_z
);

	localparam int WW = COORD_WIDTH + 17;
	localparam int RW = WW - GUARD_BITS;
	localparam logic signed [WW-1:0] RND_HALF = WW'(1) << (GUARD_BITS - 1);

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [RW-1:0] v);
		logic [RW-COORD_WIDTH:0] hi;
		hi = v[RW-1:COORD_WIDTH-1];
		priority if ((&hi) || !(|hi)) begin
			sat = v[COORD_WIDTH-1:0];
		end else if (v[RW-1]) begin
			sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
	endfunction

	logic signed [COORD_WIDTH-1:0] pa, pb;
	logic signed [WW-1:0]          ra_w, rb_w;
	logic signed [RW-1:0]          sum_a, sum_b;
	logic signed [COORD_WIDTH-1:0] res_a, res_b;
	logic signed [COORD_WIDTH-1:0] rx_n, ry_n, rz_n;

	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] rotated_x_q, rotated_y_q, rotated_z_q;

	assign ready_o = !out_valid_q || out_ready;

	always_comb begin
		unique case (ctrl_i.axis)
			AXIS_X:    begin pa = pivot_y; pb = pivot_z; end
			AXIS_Y:    begin pa = pivot_x; pb = pivot_z; end
			AXIS_Z:    begin pa = pivot_x; pb = pivot_y; end
			AXIS_NONE: begin pa = '0;      pb = '0;      end
		endcase
		// round half up, then drop the guard bits
		ra_w  = wa_i + RND_HALF;
		rb_w  = wb_i + RND_HALF;
		sum_a = $signed(ra_w[GUARD_BITS +: RW])
		      + $signed({{(RW-COORD_WIDTH){pa[COORD_WIDTH-1]}}, pa});
		sum_b = $signed(rb_w[GUARD_BITS +: RW])
		      + $signed({{(RW-COORD_WIDTH){pb[COORD_WIDTH-1]}}, pb});
		res_a = sat(sum_a);
		res_b = sat(sum_b);
		unique case (ctrl_i.axis)
			AXIS_X:    begin rx_n = cx_i;  ry_n = res_a; rz_n = res_b; end
			AXIS_Y:    begin rx_n = res_a; ry_n = cy_i;  rz_n = res_b; end
			AXIS_Z:    begin rx_n = res_a; ry_n = res_b; rz_n = cz_i;  end
			AXIS_NONE: begin rx_n = cx_i;  ry_n = cy_i;  rz_n = cz_i;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_o) begin
			out_valid_q <= ctrl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_i.valid && ready_o) begin
			rotated_x_q <= rx_n;
			rotated_y_q <= ry_n;
			rotated_z_q <= rz_n;
		end
	end

	assign out_valid = out_valid_q;
	assign rotated_x = rotated_x_q;
	assign rotated_y = rotated_y_q;
	assign rotated_z = rotated_z_q;

endmodule

// File: hw/rtl/apr_checker.sv
// ----------------------------------------------------------------------------
// apr_checker
// Port-level checks of the point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module apr_checker import apr_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] rotated_x,
	input logic signed [COORD_WIDTH-1:0] rotated_y,
	input logic signed [COORD_WIDTH-1:0] rotated_z
);

	localparam int DEPTH = CORDIC_STAGES + 3;
	localparam int CW    = $clog2(DEPTH + 1) + 1;

	logic          in_acc, out_acc;
	logic [CW-1:0] cnt_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rotated_x)
			&& $stable(rotated_y) && $stable(rotated_z))
		else $error("stalled result changed or dropped");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("more transactions in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result without a pending input");

	a_full_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'(DEPTH) && in_acc |-> out_acc)
		else $error("input taken into a full pipeline");

endmodule

bind axis_point_rotator apr_checker #(
	.COORD_WIDTH   (COORD_WIDTH),
	.CORDIC_STAGES (CORDIC_STAGES)
) u_apr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.rotated_x (rotated_x),
	.rotated_y (rotated_y),
	.rotated_z (rotated_z)
);
